// ===== sv/scss_pkg.sv =====
// ----------------------------------------------------------------------------
// scss_pkg
// Shared constants and helpers of the chart sample store.
// ----------------------------------------------------------------------------
package scss_pkg;
   localparam int MAX_SERIES_DEF = 4;
   localparam int MAX_POINTS_DEF = 256;
   localparam logic signed [31:0] RESET_RANGE_MAX = 32'sd100;
   localparam logic [8:0] RESET_POINT_COUNT = 9'd10;
   localparam logic [12:0] PIX_MAX = 13'h1fff;
   localparam int DIV_W = 64;

   localparam logic [2:0] REG_RANGE_MIN   = 3'd0;
   localparam logic [2:0] REG_RANGE_MAX   = 3'd1;
   localparam logic [2:0] REG_POINT_COUNT = 3'd2;
   localparam logic [2:0] REG_SERIES_CNT  = 3'd3;
   localparam logic [2:0] REG_AREA_X      = 3'd4;
   localparam logic [2:0] REG_AREA_Y      = 3'd5;
   localparam logic [2:0] REG_AREA_W      = 3'd6;
   localparam logic [2:0] REG_AREA_H      = 3'd7;

   localparam logic [1:0] FUNC_SET  = 2'd0;
   localparam logic [1:0] FUNC_PUSH = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   typedef struct packed {
      logic          start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic          done;
      logic [DIV_W-1:0] quo;
   } div_rsp_type;
endpackage

// ===== sv/scss_ram.sv =====
// ----------------------------------------------------------------------------
// scss_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module scss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/scss_div.sv =====
// ----------------------------------------------------------------------------
// scss_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scss_div (
   input  logic                  clock,
   input  logic                  reset,
   input  scss_pkg::div_req_type req,
   output scss_pkg::div_rsp_type rsp
);
   import scss_pkg::*;

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (req.start) begin
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         cnt_in  = 7'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next numerator bit, subtract if it fits
         trial = {rem_ff, quo_ff[DIV_W-1]} - {1'b0, den_ff};
         if (!trial[DIV_W]) begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_W-2:0], quo_ff[DIV_W-1]};
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
endmodule

// ===== sv/scrolling_chart_sample_store.sv =====
// ----------------------------------------------------------------------------
// scrolling_chart_sample_store
// Multi-series chart sample store with clamping and screen pixel mapping.
// ----------------------------------------------------------------------------
// One item is taken at a time while busy is low. A valid item runs a memory
// read, then the x division and the y division in turn on one shared 64-step
// divider, each skipped when its divisor would not be positive; a rejected
// item goes straight to ST_OUT and answers with rsp_status high. The result
// strobe rsp_valid lasts one cycle and cannot be held off. A point_count write
// starts a clearing pass over all MAX_SERIES*MAX_POINTS entries of the
// written-flag memory, during which busy is high (also once after reset).
module scrolling_chart_sample_store #(
   parameter int MAX_SERIES = scss_pkg::MAX_SERIES_DEF,
   parameter int MAX_POINTS = scss_pkg::MAX_POINTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_series_index,
   input  logic [7:0]  req_point_index,
   input  logic signed [31:0] req_sample_value,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic signed [31:0] rsp_point_value,
   output logic [12:0] rsp_pixel_x,
   output logic [12:0] rsp_pixel_y,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wr_data
);
   import scss_pkg::*;

   localparam int SW    = (MAX_SERIES > 1) ? $clog2(MAX_SERIES) : 1;
   localparam int PW    = $clog2(MAX_POINTS);
   localparam int DEPTH = MAX_SERIES * MAX_POINTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_POINTS + 1);
   localparam int SCW   = $clog2(MAX_SERIES + 1);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RD, ST_RDW, ST_XDIV, ST_XWAIT, ST_YDIV, ST_YWAIT, ST_OUT
   } state_type;

   state_type state_ff;
   logic signed [31:0] rmin_ff, rmax_ff;
   logic [8:0]  pcnt_ff;
   logic [2:0]  scnt_ff;
   logic [11:0] ax_ff, ay_ff;
   logic [12:0] aw_ff, ah_ff;
   logic [PW-1:0] head_ff [MAX_SERIES];
   logic [AW:0]   clr_ff;

   logic [1:0]  func_ff;
   logic [AW-1:0] addr_ff;
   logic [PW:0] idx_ff;
   logic signed [31:0] val_ff;
   logic [12:0] px_ff;

   logic          valid_ff, status_ff;
   logic signed [31:0] ov_ff;
   logic [12:0]   ox_ff, oy_ff;

   // effective counts
   logic [CW-1:0]  cnt;
   logic [SCW-1:0] scnt;
   assign cnt  = (32'(pcnt_ff) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(pcnt_ff);
   assign scnt = (32'(scnt_ff) > MAX_SERIES) ? SCW'(MAX_SERIES) : SCW'(scnt_ff);

   function automatic logic signed [31:0] clampv(input logic signed [31:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // request decode
   logic          bad;
   logic [SW-1:0] sidx;
   logic [PW:0]   hsum, slot;
   logic [PW-1:0] hd;
   assign sidx = SW'(req_series_index);
   assign bad  = (req_func == 2'd3) || (SCW'(req_series_index) >= scnt) ||
                 (scnt == '0 && 1'b1 && (SCW'(req_series_index) >= scnt)) ||
                 (cnt == '0) ||
                 (req_func != FUNC_PUSH && (CW'(req_point_index) >= cnt)) ||
                 (32'(req_series_index) >= MAX_SERIES);
   assign hd   = head_ff[sidx];
   always_comb begin
      hsum = (req_func == FUNC_PUSH) ? {1'b0, hd} : ({1'b0, hd} + (PW+1)'(req_point_index));
      slot = (hsum >= (PW+1)'(cnt)) ? hsum - (PW+1)'(cnt) : hsum;
   end

   // memories
   logic        dm_we, fm_we;
   logic [AW-1:0] dm_addr, fm_addr;
   logic [31:0] dm_rd;
   logic [0:0]  fm_rd, fm_wd;
   logic signed [31:0] wval;
   logic        accept;
   assign accept = start && !busy;
   assign wval   = clampv(req_sample_value, rmin_ff, rmax_ff);
   assign dm_addr = accept ? AW'(32'(sidx) * MAX_POINTS + 32'(slot)) : addr_ff;
   assign dm_we   = accept && !bad && req_func != FUNC_READ;
   assign fm_addr = (state_ff == ST_CLEAR) ? clr_ff[AW-1:0] : dm_addr;
   assign fm_we   = (state_ff == ST_CLEAR) || dm_we;
   assign fm_wd   = (state_ff == ST_CLEAR) ? 1'b0 : 1'b1;

   scss_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_data (
      .clock(clock), .wr_en(dm_we), .addr(dm_addr), .wr_data(wval), .rd_data(dm_rd));
   scss_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_flag (
      .clock(clock), .wr_en(fm_we), .addr(fm_addr), .wr_data(fm_wd), .rd_data(fm_rd));

   // divider
   div_req_type dreq;
   div_rsp_type drsp;
   logic [12:0] wm1, hm1;
   logic signed [32:0] span;
   logic [32:0] off_num;
   assign wm1  = (aw_ff != '0) ? aw_ff - 13'd1 : '0;
   assign hm1  = (ah_ff != '0) ? ah_ff - 13'd1 : '0;
   assign span = 33'(rmax_ff) - 33'(rmin_ff);
   assign off_num = 33'(33'(val_ff) - 33'(rmin_ff));
   always_comb begin
      dreq.start = 1'b0;
      dreq.num   = '0;
      dreq.den   = '0;
      if (state_ff == ST_XDIV) begin
         dreq.start = 1'b1;
         dreq.num   = DIV_W'(32'(wm1) * 32'(idx_ff));
         dreq.den   = DIV_W'(cnt) - DIV_W'(1);
      end else if (state_ff == ST_YDIV) begin
         dreq.start = 1'b1;
         dreq.num   = DIV_W'(46'(off_num) * 46'(hm1));
         dreq.den   = DIV_W'(span[32:0]);
      end
   end
   scss_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [13:0] bottom;
   logic [13:0] xsum;
   logic [13:0] ydif;
   assign bottom = 14'(ay_ff) + 14'(hm1);
   assign xsum   = 14'(ax_ff) + 14'(drsp.quo[12:0]);
   assign ydif   = bottom - 14'(drsp.quo[13:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         rmin_ff  <= '0;
         rmax_ff  <= RESET_RANGE_MAX;
         pcnt_ff  <= RESET_POINT_COUNT;
         scnt_ff  <= '0;
         ax_ff    <= '0;
         ay_ff    <= '0;
         aw_ff    <= 13'd1;
         ah_ff    <= 13'd1;
         valid_ff <= 1'b0;
         for (int i = 0; i < MAX_SERIES; i++) head_ff[i] <= '0;
      end else begin
         valid_ff <= 1'b0;
         if (csr_wr_en) begin
            case (csr_index)
               REG_RANGE_MIN:   rmin_ff <= csr_wr_data;
               REG_RANGE_MAX:   rmax_ff <= csr_wr_data;
               REG_POINT_COUNT: begin
                  pcnt_ff  <= csr_wr_data[8:0];
                  state_ff <= ST_CLEAR;
                  clr_ff   <= '0;
                  for (int i = 0; i < MAX_SERIES; i++) head_ff[i] <= '0;
               end
               REG_SERIES_CNT:  scnt_ff <= csr_wr_data[2:0];
               REG_AREA_X:      ax_ff <= csr_wr_data[11:0];
               REG_AREA_Y:      ay_ff <= csr_wr_data[11:0];
               REG_AREA_W:      aw_ff <= csr_wr_data[12:0];
               REG_AREA_H:      ah_ff <= csr_wr_data[12:0];
               default: ;
            endcase
         end
         if (!(csr_wr_en && csr_index == REG_POINT_COUNT)) begin
            case (state_ff)
               ST_CLEAR: begin
                  clr_ff <= clr_ff + 1'b1;
                  if (32'(clr_ff) == DEPTH - 1) state_ff <= ST_IDLE;
               end
               ST_IDLE: begin
                  if (start) begin
                     func_ff <= req_func;
                     addr_ff <= dm_addr;
                     val_ff  <= wval;
                     idx_ff  <= (req_func == FUNC_PUSH) ? (PW+1)'(cnt - 1'b1)
                                                        : (PW+1)'(req_point_index);
                     if (!bad && req_func == FUNC_PUSH) begin
                        head_ff[sidx] <= PW'((slot + 1'b1 >= (PW+1)'(cnt)) ? '0
                                                                          : slot + 1'b1);
                     end
                     state_ff <= bad ? ST_OUT : ST_RD;
                  end
               end
               ST_RD:  state_ff <= ST_RDW;
               ST_RDW: begin
                  if (func_ff == FUNC_READ) begin
                     val_ff <= fm_rd[0] ? clampv(dm_rd, rmin_ff, rmax_ff) : rmin_ff;
                  end
                  state_ff <= ST_XDIV;
               end
               ST_XDIV: begin
                  if (cnt <= CW'(1)) begin
                     px_ff    <= 13'(ax_ff);
                     state_ff <= ST_YDIV;
                  end else begin
                     state_ff <= ST_XWAIT;
                  end
               end
               ST_XWAIT: begin
                  if (drsp.done) begin
                     px_ff    <= (xsum > 14'(PIX_MAX)) ? PIX_MAX : xsum[12:0];
                     state_ff <= ST_YDIV;
                  end
               end
               ST_YDIV: begin
                  if (span <= 0) begin
                     valid_ff  <= 1'b1;
                     status_ff <= 1'b0;
                     ov_ff     <= val_ff;
                     ox_ff     <= px_ff;
                     oy_ff     <= (bottom > 14'(PIX_MAX)) ? PIX_MAX : bottom[12:0];
                     state_ff  <= ST_IDLE;
                  end else begin
                     state_ff <= ST_YWAIT;
                  end
               end
               ST_YWAIT: begin
                  if (drsp.done) begin
                     valid_ff  <= 1'b1;
                     status_ff <= 1'b0;
                     ov_ff     <= val_ff;
                     ox_ff     <= px_ff;
                     oy_ff     <= (ydif > 14'(PIX_MAX)) ? PIX_MAX : ydif[12:0];
                     state_ff  <= ST_IDLE;
                  end
               end
               ST_OUT: begin
                  valid_ff  <= 1'b1;
                  status_ff <= 1'b1;
                  ov_ff     <= rmin_ff;
                  ox_ff     <= '0;
                  oy_ff     <= '0;
                  state_ff  <= ST_IDLE;
               end
               default: state_ff <= ST_IDLE;
            endcase
         end
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_point_value = ov_ff;
   assign rsp_pixel_x     = ox_ff;
   assign rsp_pixel_y     = oy_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !accept) else $error("item taken while busy");
   a_reject_fast: assert property (@(posedge clock) disable iff (reset)
      (accept && bad && !csr_wr_en) |=> ##1 (rsp_valid && rsp_status))
      else $error("rejected item without result");
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_pixel_x == '0 && rsp_pixel_y == '0))
      else $error("rejected result carries pixel");
endmodule
